/* design/xoshiro256ss_bounded_rng_macros.svh */
// ----------------------------------------------------------------------------
// xoshiro256** bounded generator assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256SS_BOUNDED_RNG_MACROS_SVH
`define XOSHIRO256SS_BOUNDED_RNG_MACROS_SVH

// same-cycle implication
`define XSR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("xsr same-cycle check failed");

// next-cycle implication
`define XSR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("xsr next-cycle check failed");

`endif

/* design/xsr_pkg.sv */
// ----------------------------------------------------------------------------
// xsr_pkg
// Types and constants of the xoshiro256** bounded generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xsr_pkg;

   localparam int unsigned WORD_W      = 64;
   localparam int unsigned HALF_W      = 32;
   localparam int unsigned STATE_WORDS = 4;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned DIV_STEPS   = HALF_W;

   localparam logic [WORD_W-1:0] MIX_GOLDEN   = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_C1       = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_C2       = 64'h94D0_49BB_1331_11EB;
   localparam logic [WORD_W-1:0] SEED_DEFAULT = 64'h1234_5678_ABCD_EF01;

   localparam logic [0:0] REG_SEED = 1'b0;

   localparam logic [1:0] KIND_RESEED  = 2'd0;
   localparam logic [1:0] KIND_RAW     = 2'd1;
   localparam logic [1:0] KIND_BOUNDED = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   // splitmix64 sequencer phases
   localparam logic [3:0] PH_ADD   = 4'd0;
   localparam logic [3:0] PH_LL1   = 4'd1;
   localparam logic [3:0] PH_LH1   = 4'd2;
   localparam logic [3:0] PH_HL1   = 4'd3;
   localparam logic [3:0] PH_FOLD1 = 4'd4;
   localparam logic [3:0] PH_LL2   = 4'd5;
   localparam logic [3:0] PH_LH2   = 4'd6;
   localparam logic [3:0] PH_HL2   = 4'd7;
   localparam logic [3:0] PH_FOLD2 = 4'd8;

   localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);
   localparam logic [1:0] WORD_LAST = 2'(STATE_WORDS - 1);

   typedef enum logic [1:0] {
      CMD_RESEED,
      CMD_RAW,
      CMD_BOUNDED,
      CMD_NONE
   } xsr_op_type;

   typedef struct packed {
      xsr_op_type        op;
      logic [HALF_W-1:0] bound;
   } xsr_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } xsr_qstat_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MIX    = 7'b0000010,
      ST_STEP   = 7'b0000100,
      ST_BSTEP  = 7'b0001000,
      ST_BMUL   = 7'b0010000,
      ST_BCHECK = 7'b0100000,
      ST_DIV    = 7'b1000000
   } xsr_state_type;

endpackage

`default_nettype wire

/* design/xsr_front.sv */
// ----------------------------------------------------------------------------
// xsr_front
// Request intake: classify each item and push it into the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module xsr_front
   import xsr_pkg::*;
(
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_kind,
   input  wire logic [31:0]   req_bound,
   input  wire xsr_qstat_type q_stat,
   output logic               q_push,
   output xsr_cmd_type        q_cmd
);

   xsr_op_type op;

   always_comb begin
      unique case (req_kind)
         KIND_RESEED:  op = CMD_RESEED;
         KIND_RAW:     op = CMD_RAW;
         KIND_BOUNDED: op = CMD_BOUNDED;
         default:      op = CMD_NONE;
      endcase
   end

   assign req_ready   = !q_stat.full;
   assign q_push      = req_valid && !q_stat.full;
   assign q_cmd.op    = op;
   assign q_cmd.bound = req_bound;

endmodule

`default_nettype wire

/* design/xsr_queue.sv */
// ----------------------------------------------------------------------------
// xsr_queue
// Short command queue between intake and generator engine.
// ----------------------------------------------------------------------------
`default_nettype none

module xsr_queue
   import xsr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire xsr_cmd_type push_cmd,
   input  wire logic        pop,
   output xsr_cmd_type      head_cmd,
   output xsr_qstat_type    stat
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   xsr_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* design/xsr_engine.sv */
// ----------------------------------------------------------------------------
// xsr_engine
// Generator engine: state words, splitmix64 fill, xoshiro256** step,
// Lemire bounded draw with shared 32x32 multiplier and serial threshold divider.
// ----------------------------------------------------------------------------
`default_nettype none

module xsr_engine
   import xsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire xsr_cmd_type       cmd,
   output logic                   cmd_pop,
   input  wire logic [WORD_W-1:0] seed_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [WORD_W-1:0]      rsp_value
);

   xsr_state_type     state_ff, state_in;
   logic [WORD_W-1:0] s_ff [STATE_WORDS];
   logic [WORD_W-1:0] s_in [STATE_WORDS];
   logic [WORD_W-1:0] step_s [STATE_WORDS];
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] op_ff, op_in;
   logic [WORD_W-1:0] mul_ff, mul_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [3:0]        ph_ff, ph_in;
   logic [1:0]        word_ff, word_in;
   logic              reseed_rsp_ff, reseed_rsp_in;
   logic [HALF_W-1:0] bound_ff, bound_in;
   logic [HALF_W-1:0] x_ff, x_in;
   logic [HALF_W-1:0] thr_ff, thr_in;
   logic              thr_valid_ff, thr_valid_in;
   logic [HALF_W-1:0] rem_ff, rem_in;
   logic [HALF_W-1:0] dvd_ff, dvd_in;
   logic [4:0]        div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;

   logic              out_free;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic              mul_en;
   logic [WORD_W-1:0] mul_prod;
   logic [WORD_W-1:0] mix_const;
   logic [WORD_W-1:0] acc_add;
   logic [WORD_W-1:0] mix_z;
   logic [WORD_W-1:0] s1x5, s1rot, step_res, t17, n2, n3;
   logic [HALF_W:0]   rem_shift;
   logic [HALF_W-1:0] rem_new;
   logic [HALF_W-1:0] low;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // xoshiro256** step
   assign s1x5      = s_ff[1] + {s_ff[1][WORD_W-3:0], 2'b00};
   assign s1rot     = {s1x5[WORD_W-8:0], s1x5[WORD_W-1:WORD_W-7]};
   assign step_res  = s1rot + {s1rot[WORD_W-4:0], 3'b000};
   assign t17       = {s_ff[1][WORD_W-18:0], 17'b0};
   assign n2        = s_ff[2] ^ s_ff[0];
   assign n3        = s_ff[3] ^ s_ff[1];
   assign step_s[0] = s_ff[0] ^ n3;
   assign step_s[1] = s_ff[1] ^ n2;
   assign step_s[2] = n2 ^ t17;
   assign step_s[3] = {n3[18:0], n3[WORD_W-1:19]};

   // splitmix64 helpers
   assign mix_const = (ph_ff < PH_LL2) ? MIX_C1 : MIX_C2;
   assign acc_add   = acc_ff + MIX_GOLDEN;
   assign mix_z     = sum_ff + {mul_ff[HALF_W-1:0], {HALF_W{1'b0}}};

   // threshold divider
   assign rem_shift = {rem_ff, dvd_ff[HALF_W-1]};
   assign rem_new   = (rem_shift >= {1'b0, bound_ff}) ?
                      HALF_W'(rem_shift - {1'b0, bound_ff}) : rem_shift[HALF_W-1:0];

   assign low      = mul_ff[HALF_W-1:0];
   assign mul_prod = WORD_W'(mul_a) * WORD_W'(mul_b);

   always_comb begin
      mul_a = x_ff;
      mul_b = bound_ff;
      mul_en = 1'b0;
      if (state_ff == ST_MIX) begin
         case (ph_ff) inside
            PH_LL1, PH_LL2: begin
               mul_a  = op_ff[HALF_W-1:0];
               mul_b  = mix_const[HALF_W-1:0];
               mul_en = 1'b1;
            end
            PH_LH1, PH_LH2: begin
               mul_a  = op_ff[HALF_W-1:0];
               mul_b  = mix_const[WORD_W-1:HALF_W];
               mul_en = 1'b1;
            end
            PH_HL1, PH_HL2: begin
               mul_a  = op_ff[WORD_W-1:HALF_W];
               mul_b  = mix_const[HALF_W-1:0];
               mul_en = 1'b1;
            end
            default: begin
               mul_en = 1'b0;
            end
         endcase
      end else if (state_ff == ST_BMUL) begin
         mul_en = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      s_in          = s_ff;
      acc_in        = acc_ff;
      op_in         = op_ff;
      mul_in        = mul_en ? mul_prod : mul_ff;
      sum_in        = sum_ff;
      ph_in         = ph_ff;
      word_in       = word_ff;
      reseed_rsp_in = reseed_rsp_ff;
      bound_in      = bound_ff;
      x_in          = x_ff;
      thr_in        = thr_ff;
      thr_valid_in  = thr_valid_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      cmd_pop       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  CMD_RESEED: begin
                     acc_in        = (seed_value == '0) ? SEED_DEFAULT : seed_value;
                     ph_in         = PH_ADD;
                     word_in       = '0;
                     reseed_rsp_in = 1'b1;
                     state_in      = ST_MIX;
                  end
                  CMD_RAW: begin
                     state_in = ST_STEP;
                  end
                  CMD_BOUNDED: begin
                     bound_in     = cmd.bound;
                     thr_valid_in = 1'b0;
                     state_in     = ST_BSTEP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                  end
               endcase
            end
         end
         ST_MIX: begin
            ph_in = ph_ff + 4'd1;
            case (ph_ff) inside
               PH_ADD: begin
                  acc_in = acc_add;
                  op_in  = acc_add ^ (acc_add >> 30);
               end
               PH_LH1, PH_LH2: begin
                  sum_in = mul_ff;
               end
               PH_HL1, PH_HL2: begin
                  sum_in = mix_z;
               end
               PH_FOLD1: begin
                  op_in = mix_z ^ (mix_z >> 27);
               end
               PH_FOLD2: begin
                  s_in[word_ff] = mix_z ^ (mix_z >> 31);
                  ph_in         = PH_ADD;
                  word_in       = word_ff + 2'd1;
                  if (word_ff == WORD_LAST) begin
                     state_in = ST_IDLE;
                     if (reseed_rsp_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        reseed_rsp_in = 1'b0;
                     end
                  end
               end
               default: begin
                  sum_in = sum_ff;
               end
            endcase
         end
         ST_STEP: begin
            s_in         = step_s;
            rsp_valid_in = 1'b1;
            rsp_value_in = step_res;
            state_in     = ST_IDLE;
         end
         ST_BSTEP: begin
            s_in     = step_s;
            x_in     = step_res[HALF_W-1:0];
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            state_in = ST_BCHECK;
         end
         ST_BCHECK: begin
            if (thr_valid_ff ? (low < thr_ff) : 1'b0) begin
               state_in = ST_BSTEP;
            end else if (!thr_valid_ff && (low < bound_ff)) begin
               rem_in     = '0;
               dvd_in     = HALF_W'(0) - bound_ff;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_value_in = {{HALF_W{1'b0}}, mul_ff[WORD_W-1:HALF_W]};
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            rem_in     = rem_new;
            dvd_in     = {dvd_ff[HALF_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST) begin
               thr_in       = rem_new;
               thr_valid_in = 1'b1;
               state_in     = ST_BCHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_MIX;
         acc_ff        <= SEED_DEFAULT;
         ph_ff         <= PH_ADD;
         word_ff       <= '0;
         reseed_rsp_ff <= 1'b0;
         thr_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         ph_ff         <= ph_in;
         word_ff       <= word_in;
         reseed_rsp_ff <= reseed_rsp_in;
         thr_valid_ff  <= thr_valid_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      op_ff        <= op_in;
      mul_ff       <= mul_in;
      sum_ff       <= sum_in;
      bound_ff     <= bound_in;
      x_ff         <= x_in;
      thr_ff       <= thr_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

`default_nettype wire

/* design/xoshiro256ss_bounded_rng.sv */
// ----------------------------------------------------------------------------
// xoshiro256ss_bounded_rng
// xoshiro256** generator with reseed, raw and bounded (Lemire) draws.
//
// Usage:
//   req_* carries one item (req_kind, req_bound) on a valid/ready handshake;
//   rsp_* returns exactly one rsp_value per item, in order.
//   csr_* is an APB-style port holding the 64-bit seed register at addresses 0-7;
//   writing it does not reseed, a reseed item does.
//   Items pass a two-entry queue into the engine, which takes one at a time.
//   Engine work per item: raw takes one xoshiro256** step; an unused kind returns 0;
//   bounded steps, multiplies and checks, redrawing on a rejected draw, and derives
//   the threshold once when needed (one bit per cycle in the remainder unit); reseed
//   fills four splitmix64 words on the shared 32x32 multiplier.
//   Reset starts a state fill from the default seed; items are queued
//   meanwhile and served after it.
//   A stalled rsp_ready holds the result in the output register; the engine
//   waits with its next item while that register is occupied, and the queue
//   keeps taking items until full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xoshiro256ss_bounded_rng_macros.svh"

module xoshiro256ss_bounded_rng
   import xsr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_kind,
   input  wire logic [31:0]           req_bound,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [63:0]                rsp_value,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0]           csr_pwdata,
   output logic [63:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [WORD_W-1:0] seed_ff, seed_in;
   logic              csr_write;
   logic              seed_sel;
   xsr_qstat_type     q_stat;
   xsr_cmd_type       push_cmd, head_cmd;
   logic              q_push, q_pop;

   assign csr_pready = 1'b1;
   assign seed_sel   = (csr_paddr[CSR_ADDR_W-1] == REG_SEED);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seed_in    = (csr_write && seed_sel) ? csr_pwdata : seed_ff;
   assign csr_prdata = seed_sel ? seed_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   xsr_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_bound (req_bound),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   xsr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   xsr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!q_stat.empty),
      .cmd        (head_cmd),
      .cmd_pop    (q_pop),
      .seed_value (seed_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value)
   );

   `XSR_ASSERT_IMP(a_no_push_when_full, q_stat.full, !q_push)
   `XSR_ASSERT_IMP(a_pop_only_when_free, q_pop, !q_stat.empty && (!rsp_valid || rsp_ready))
   `XSR_ASSERT_NXT(a_push_leaves_entry, q_push, !q_stat.empty)

endmodule

`default_nettype wire
